FILE: hw/rtl/sls_pkg.sv
`default_nettype none

package sls_pkg;

  // Channel count and the width of every per-channel mask.
  localparam int unsigned NumChannels = 3;
  localparam int unsigned MaskW       = 3;
  localparam int unsigned ChanW       = 2;
  localparam int unsigned TimeW       = 32;
  localparam int unsigned IntervalW   = 16;
  localparam int unsigned SampleIdW   = 3;

  // Channels that exist, as a mask.
  localparam logic [MaskW-1:0] ChMask = MaskW'((1 << NumChannels) - 1);

  // Interval after reset.
  localparam logic [IntervalW-1:0] IntervalReset = IntervalW'(100);

  // Event codes carried by the operation field.
  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_DATA = 2'd1,
    OP_POLL = 2'd2
  } op_e;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_ACCEL_EN = 2'd0,
    REG_GYRO_EN  = 2'd1,
    REG_INTERVAL = 2'd2
  } reg_e;

  // One input beat as held in the input register.
  typedef struct packed {
    logic [1:0]       operation;
    logic [TimeW-1:0] time_ms;
    logic [MaskW-1:0] comm_ok_mask;
    logic [ChanW-1:0] irq_channel;
    logic             irq_is_gyro;
  } item_t;

  // One result beat as held in the output register.
  typedef struct packed {
    logic                 change_found;
    logic [ChanW-1:0]     change_channel;
    logic                 change_connected;
    logic [MaskW-1:0]     connected_mask;
    logic [MaskW-1:0]     configure_mask;
    logic                 sample_accepted;
    logic [SampleIdW-1:0] sample_id;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/sensor_link_supervisor.sv
// Throughput: one event per cycle while out_ready_i does not stall the result
// register; the input register and the result register form a two-stage
// pipeline, and the supervision state updates as an event leaves the input
// register. Configuration writes are never stalled.
// Reset clears all connection, data-received and change bits, the last check
// time and both enable masks, and sets the update interval to 100 ms.
`default_nettype none

module sensor_link_supervisor import sls_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [1:0]           cfg_index_i,
  input  wire logic [IntervalW-1:0] cfg_data_i,
  // Event input channel
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [1:0]           operation_i,
  input  wire logic [TimeW-1:0]     time_ms_i,
  input  wire logic [MaskW-1:0]     comm_ok_mask_i,
  input  wire logic [ChanW-1:0]     irq_channel_i,
  input  wire logic                 irq_is_gyro_i,
  // Result channel
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic                      change_found_o,
  output logic [ChanW-1:0]          change_channel_o,
  output logic                      change_connected_o,
  output logic [MaskW-1:0]          connected_mask_o,
  output logic [MaskW-1:0]          configure_mask_o,
  output logic                      sample_accepted_o,
  output logic [SampleIdW-1:0]      sample_id_o
);

  // Configuration registers
  logic [MaskW-1:0]     accel_en_q;
  logic [MaskW-1:0]     gyro_en_q;
  logic [IntervalW-1:0] interval_q;

  // Supervision state
  logic [MaskW-1:0] connected_q, connected_d;
  logic [MaskW-1:0] received_q, received_d;
  logic [MaskW-1:0] changed_q, changed_d;
  logic [TimeW-1:0] last_check_q, last_check_d;

  // Pipeline registers
  logic    in_valid_q;
  item_t   item_q;
  logic    out_valid_q;
  result_t res_q, res_d;

  logic out_free;
  logic advance;

  // The result register can load when empty or when its beat leaves now.
  assign out_free   = !out_valid_q || out_ready_i;
  assign advance    = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || out_free;
  assign cfg_ready_o = 1'b1;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_en_q <= '0;
      gyro_en_q  <= '0;
      interval_q <= IntervalReset;
    end else if (cfg_valid_i) begin
      case (reg_e'(cfg_index_i))
        REG_ACCEL_EN: accel_en_q <= cfg_data_i[MaskW-1:0];
        REG_GYRO_EN:  gyro_en_q  <= cfg_data_i[MaskW-1:0];
        REG_INTERVAL: interval_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  // Input register: payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q.operation    <= operation_i;
      item_q.time_ms      <= time_ms_i;
      item_q.comm_ok_mask <= comm_ok_mask_i;
      item_q.irq_channel  <= irq_channel_i;
      item_q.irq_is_gyro  <= irq_is_gyro_i;
    end
  end

  // Event evaluation: next state and the result beat.
  always_comb begin
    logic [TimeW-1:0] elapsed;
    logic [MaskW-1:0] measuring;
    logic [MaskW-1:0] comm_ok;
    logic [MaskW-1:0] ch_dec;
    logic [MaskW-1:0] kind_en;
    logic             found;

    connected_d  = connected_q;
    received_d   = received_q;
    changed_d    = changed_q;
    last_check_d = last_check_q;
    res_d        = '0;

    elapsed   = item_q.time_ms - last_check_q;
    measuring = (accel_en_q | gyro_en_q) & ChMask;
    comm_ok   = item_q.comm_ok_mask & ChMask;
    ch_dec    = ChMask & (MaskW'(1) << item_q.irq_channel);
    kind_en   = item_q.irq_is_gyro ? gyro_en_q : accel_en_q;
    found     = 1'b0;

    case (op_e'(item_q.operation))
      OP_TICK: begin
        // Supervision check once the interval has been exceeded.
        if (elapsed > TimeW'(interval_q)) begin
          for (int i = 0; i < NumChannels; i++) begin
            if (!connected_q[i]) begin
              if (comm_ok[i]) begin
                connected_d[i]          = 1'b1;
                changed_d[i]            = 1'b1;
                res_d.configure_mask[i] = 1'b1;
              end
            end else if (!measuring[i]) begin
              if (!comm_ok[i]) begin
                connected_d[i] = 1'b0;
                changed_d[i]   = 1'b1;
              end
            end else if (received_q[i]) begin
              received_d[i] = 1'b0;
            end else begin
              connected_d[i] = 1'b0;
              changed_d[i]   = 1'b1;
            end
          end
          last_check_d = item_q.time_ms;
        end
      end
      OP_DATA: begin
        // Data arrival counts only for an enabled measurement kind.
        res_d.sample_id = {item_q.irq_channel, item_q.irq_is_gyro};
        if ((kind_en & ch_dec) != '0) begin
          received_d            = received_q | ch_dec;
          res_d.sample_accepted = 1'b1;
        end
      end
      OP_POLL: begin
        // Report and clear the lowest pending change.
        for (int i = 0; i < NumChannels; i++) begin
          if (!found && changed_q[i]) begin
            found                  = 1'b1;
            changed_d[i]           = 1'b0;
            res_d.change_found     = 1'b1;
            res_d.change_channel   = ChanW'(i);
            res_d.change_connected = connected_q[i];
          end
        end
      end
      default: ;
    endcase

    res_d.connected_mask = connected_d;
  end

  // Supervision state update as an event is evaluated.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      connected_q  <= '0;
      received_q   <= '0;
      changed_q    <= '0;
      last_check_q <= '0;
    end else if (advance) begin
      connected_q  <= connected_d;
      received_q   <= received_d;
      changed_q    <= changed_d;
      last_check_q <= last_check_d;
    end
  end

  // Result register: valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= in_valid_q;
    end
  end

  // Result register: payload.
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign change_found_o     = res_q.change_found;
  assign change_channel_o   = res_q.change_channel;
  assign change_connected_o = res_q.change_connected;
  assign connected_mask_o   = res_q.connected_mask;
  assign configure_mask_o   = res_q.configure_mask;
  assign sample_accepted_o  = res_q.sample_accepted;
  assign sample_id_o        = res_q.sample_id;

  // A channel flagged for configuration must be connected in the same beat.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((configure_mask_o & ~connected_mask_o) == '0))
    else $error("configure flag on a channel that is not connected");

  // A beat reports at most one kind of event.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $countones({change_found_o, sample_accepted_o,
                                (configure_mask_o != '0)}) <= 1)
    else $error("result beat mixes event kinds");

  // Supervision state only moves when an event is evaluated.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> ($stable(connected_q) && $stable(changed_q) && $stable(received_q)))
    else $error("supervision state changed without an event");

  // A reported change was pending and is cleared by the poll.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_d.change_found) |=>
      !changed_q[$past(res_d.change_channel)])
    else $error("polled change bit not cleared");

  // Bits of channels that do not exist never become set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((connected_q | received_q | changed_q) & ~ChMask) == '0)
    else $error("state bit set for a missing channel");

endmodule

`default_nettype wire

FILE: tb/tb_sensor_link_supervisor.sv
`timescale 1ns / 1ps

module tb_sensor_link_supervisor;
  import sls_pkg::*;

  localparam int unsigned TimeoutCycles = 200000;
  localparam int unsigned HoldCycles    = 120;
  localparam int unsigned MaxShown      = 10;
  localparam int unsigned RandomPhases  = 7;
  localparam int unsigned PhaseEvents   = 105;
  localparam int unsigned PressurePhase = 3;

  // Operation code with no meaning, and a register index with no register behind it.
  localparam logic [1:0] OpReserved = 2'd3;
  localparam logic [1:0] RegUnused  = 2'd3;

  typedef struct packed {
    logic [1:0]           index;
    logic [IntervalW-1:0] data;
  } reg_write_t;

  // Clock, reset and every block input, known from time zero.
  logic                 clk_i              = 1'b0;
  logic                 rst_ni             = 1'b0;
  logic                 cfg_valid_i        = 1'b0;
  logic [1:0]           cfg_index_i        = '0;
  logic [IntervalW-1:0] cfg_data_i         = '0;
  logic                 in_valid_i         = 1'b0;
  logic [1:0]           operation_i        = '0;
  logic [TimeW-1:0]     time_ms_i          = '0;
  logic [MaskW-1:0]     comm_ok_mask_i     = '0;
  logic [ChanW-1:0]     irq_channel_i      = '0;
  logic                 irq_is_gyro_i      = 1'b0;
  logic                 out_ready_i        = 1'b0;
  logic                 cfg_ready_o;
  logic                 in_ready_o;
  logic                 out_valid_o;
  logic                 change_found_o;
  logic [ChanW-1:0]     change_channel_o;
  logic                 change_connected_o;
  logic [MaskW-1:0]     connected_mask_o;
  logic [MaskW-1:0]     configure_mask_o;
  logic                 sample_accepted_o;
  logic [SampleIdW-1:0] sample_id_o;

  sensor_link_supervisor dut (.*);

  always #5 clk_i = ~clk_i;

  // Supervisor state as predicted by the testbench.
  logic [MaskW-1:0]     accel_en_m;
  logic [MaskW-1:0]     gyro_en_m;
  logic [IntervalW-1:0] interval_m;
  logic [MaskW-1:0]     linked_m;
  logic [MaskW-1:0]     heard_m;
  logic [MaskW-1:0]     pending_m;
  logic [TimeW-1:0]     last_check_m;

  // Pending event beats, pending register writes and outstanding result beats.
  item_t      event_q[$];
  reg_write_t write_q[$];
  result_t    outcome_q[$];

  // Run statistics.
  int unsigned mismatches = 0;
  int unsigned n_ticks = 0, n_checks = 0, n_data = 0, n_polls = 0, n_reserved = 0;
  int unsigned n_links = 0, n_drops = 0, n_samples = 0, n_changes = 0;
  int unsigned input_stalls = 0;

  function automatic void reset_supervisor();
    accel_en_m   = '0;
    gyro_en_m    = '0;
    interval_m   = IntervalReset;
    linked_m     = '0;
    heard_m      = '0;
    pending_m    = '0;
    last_check_m = '0;
  endfunction

  function automatic void apply_write(input reg_write_t w);
    case (w.index)
      REG_ACCEL_EN: accel_en_m = w.data[MaskW-1:0];
      REG_GYRO_EN:  gyro_en_m  = w.data[MaskW-1:0];
      REG_INTERVAL: interval_m = w.data;
      default: ;
    endcase
  endfunction

  // Advances the supervisor by one event and returns the result beat it yields.
  function automatic result_t supervise(input item_t evt);
    result_t          res;
    logic [MaskW-1:0] measuring;
    logic [MaskW-1:0] passing;
    logic [TimeW-1:0] elapsed;
    logic             enabled;
    int               i;
    res = '0;
    case (evt.operation)
      OP_TICK: begin
        n_ticks++;
        elapsed = evt.time_ms - last_check_m;
        if (elapsed > TimeW'(interval_m)) begin
          n_checks++;
          measuring = (accel_en_m | gyro_en_m) & ChMask;
          passing = evt.comm_ok_mask & ChMask;
          for (i = 0; i < NumChannels; i++) begin
            if (!linked_m[i]) begin
              // A new sensor answers: link it and ask for configuration.
              if (passing[i]) begin
                linked_m[i] = 1'b1;
                pending_m[i] = 1'b1;
                res.configure_mask[i] = 1'b1;
              end
            end else if (!measuring[i]) begin
              if (!passing[i]) begin
                linked_m[i] = 1'b0;
                pending_m[i] = 1'b1;
              end
            end else if (heard_m[i]) begin
              heard_m[i] = 1'b0;
            end else begin
              // Measuring, but silent since the last check.
              linked_m[i] = 1'b0;
              pending_m[i] = 1'b1;
            end
          end
          n_links += $countones(res.configure_mask);
          last_check_m = evt.time_ms;
        end
      end
      OP_DATA: begin
        n_data++;
        res.sample_id = {evt.irq_channel, evt.irq_is_gyro};
        if (evt.irq_channel < NumChannels) begin
          enabled = evt.irq_is_gyro ? gyro_en_m[evt.irq_channel]
                                    : accel_en_m[evt.irq_channel];
          if (enabled) begin
            heard_m[evt.irq_channel] = 1'b1;
            res.sample_accepted = 1'b1;
            n_samples++;
          end
        end
      end
      OP_POLL: begin
        n_polls++;
        for (i = 0; i < NumChannels; i++) begin
          if (pending_m[i] && !res.change_found) begin
            pending_m[i] = 1'b0;
            res.change_found = 1'b1;
            res.change_channel = ChanW'(i);
            res.change_connected = linked_m[i];
            n_changes++;
          end
        end
      end
      // The reserved code leaves the state alone.
      default: n_reserved++;
    endcase
    res.connected_mask = linked_m;
    return res;
  endfunction

  function automatic int unsigned draw_gap(input bit steady);
    return steady ? 0 : $urandom_range(0, 8);
  endfunction

  // Event sender: one beat in flight, drawn from the event queue.
  item_t       sent_item;
  int unsigned tx_gap = 0;
  bit          tx_steady = 1'b0;
  logic [MaskW-1:0] linked_before;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_ready_o) begin
        input_stalls++;
      end
      if (in_valid_i && in_ready_o) begin
        linked_before = linked_m;
        outcome_q.push_back(supervise(sent_item));
        n_drops += $countones(linked_before & ~linked_m);
        tx_gap = draw_gap(tx_steady);
        if ($urandom_range(0, 63) == 0) begin
          tx_steady = !tx_steady;
        end
      end
      if (!in_valid_i || in_ready_o) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid_i <= 1'b0;
        end else if (event_q.size() != 0) begin
          sent_item = event_q.pop_front();
          in_valid_i <= 1'b1;
          operation_i <= sent_item.operation;
          time_ms_i <= sent_item.time_ms;
          comm_ok_mask_i <= sent_item.comm_ok_mask;
          irq_channel_i <= sent_item.irq_channel;
          irq_is_gyro_i <= sent_item.irq_is_gyro;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Register writer: only fed while the block is idle.
  reg_write_t sent_write;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_valid_i && cfg_ready_o) begin
        apply_write(sent_write);
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (write_q.size() != 0) begin
          sent_write = write_q.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= sent_write.index;
          cfg_data_i <= sent_write.data;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, started on request from the stimulus.
  int unsigned hold_left = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_seen = 0;

  always @(posedge clk_i) begin
    if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result receiver and checker.
  int unsigned rx_wait = 0;
  bit          rx_steady = 1'b0;
  result_t     got;
  result_t     want;
  string       bad;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = {change_found_o, change_channel_o, change_connected_o, connected_mask_o,
               configure_mask_o, sample_accepted_o, sample_id_o};
        if (outcome_q.size() == 0) begin
          mismatches++;
          if (mismatches <= MaxShown) begin
            $display("[%0t] result beat with nothing outstanding: %h", $realtime, got);
          end
        end else begin
          want = outcome_q.pop_front();
          bad = "";
          if (got.change_found !== want.change_found) bad = {bad, " change_found"};
          if (got.change_channel !== want.change_channel) bad = {bad, " change_channel"};
          if (got.change_connected !== want.change_connected) bad = {bad, " change_connected"};
          if (got.connected_mask !== want.connected_mask) bad = {bad, " connected_mask"};
          if (got.configure_mask !== want.configure_mask) bad = {bad, " configure_mask"};
          if (got.sample_accepted !== want.sample_accepted) bad = {bad, " sample_accepted"};
          if (got.sample_id !== want.sample_id) bad = {bad, " sample_id"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= MaxShown) begin
              $display("[%0t] mismatch in%s: expected %h, got %h", $realtime, bad, want, got);
            end
          end
        end
        rx_wait = draw_gap(rx_steady);
        if ($urandom_range(0, 63) == 0) begin
          rx_steady = !rx_steady;
        end
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      out_ready_i <= (rx_wait == 0) && (hold_left == 0);
    end
  end

  // Watchdog.
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == TimeoutCycles) begin
      $display("Timed out after %0d cycles with %0d results outstanding.",
               cycle_count, outcome_q.size());
      $display("sensor_link_supervisor regression: fail");
      $finish;
    end
  end

  // Stimulus helpers.
  logic [TimeW-1:0] now_ms = '0;

  task automatic push_event(input logic [1:0] op, input logic [TimeW-1:0] t,
                            input logic [MaskW-1:0] ok, input logic [ChanW-1:0] ch,
                            input logic gyro);
    item_t evt;
    evt.operation = op;
    evt.time_ms = t;
    evt.comm_ok_mask = ok;
    evt.irq_channel = ch;
    evt.irq_is_gyro = gyro;
    event_q.push_back(evt);
  endtask

  task automatic tick(input logic [TimeW-1:0] t, input logic [MaskW-1:0] ok);
    now_ms = t;
    push_event(OP_TICK, t, ok, '0, 1'b0);
  endtask

  task automatic sample_irq(input logic [ChanW-1:0] ch, input logic gyro);
    push_event(OP_DATA, '0, '0, ch, gyro);
  endtask

  task automatic poll(input int unsigned count);
    repeat (count) push_event(OP_POLL, '0, '0, '0, 1'b0);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [IntervalW-1:0] data);
    reg_write_t w;
    w.index = index;
    w.data = data;
    write_q.push_back(w);
  endtask

  // Waits until every beat has gone through and the pipeline has drained.
  task automatic settle();
    while (event_q.size() != 0 || write_q.size() != 0 || in_valid_i || cfg_valid_i ||
           outcome_q.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (4) @(negedge clk_i);
  endtask

  task automatic random_setup();
    logic [IntervalW-1:0] span;
    case ($urandom_range(0, 3))
      0: span = '0;
      1: span = '1;
      2: span = IntervalW'($urandom_range(1, 30));
      default: span = IntervalW'($urandom_range(31, 2000));
    endcase
    write_reg(REG_ACCEL_EN, IntervalW'($urandom));
    write_reg(REG_GYRO_EN, IntervalW'($urandom));
    write_reg(REG_INTERVAL, span);
    if ($urandom_range(0, 2) == 0) begin
      write_reg(RegUnused, IntervalW'($urandom));
    end
    settle();
  endtask

  // Random events; fields a given operation ignores carry noise.
  task automatic random_events(input int unsigned count);
    item_t            evt;
    int unsigned      pick;
    logic [TimeW-1:0] step;
    int               i;
    repeat (count) begin
      evt.time_ms = $urandom;
      evt.comm_ok_mask = MaskW'($urandom);
      evt.irq_channel = ChanW'($urandom);
      evt.irq_is_gyro = 1'($urandom);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        evt.operation = OP_TICK;
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8: step = TimeW'(interval_m) + 1 + $urandom_range(0, 40);
          9, 10, 11, 12, 13, 14: step = $urandom_range(0, interval_m);
          15, 16, 17: step = TimeW'(interval_m);
          default: step = $urandom;
        endcase
        now_ms = now_ms + step;
        evt.time_ms = now_ms;
        // Each sensor mostly answers its communication test.
        for (i = 0; i < MaskW; i++) begin
          evt.comm_ok_mask[i] = ($urandom_range(0, 3) != 0);
        end
      end else if (pick < 70) begin
        evt.operation = OP_DATA;
        evt.irq_channel = ($urandom_range(0, 15) == 0) ? 2'd3 : ChanW'($urandom_range(0, 2));
      end else if (pick < 95) begin
        evt.operation = OP_POLL;
      end else begin
        evt.operation = OpReserved;
      end
      event_q.push_back(evt);
    end
  endtask

  initial begin
    reset_supervisor();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset settings: nothing measures, interval of 100 ms.
    poll(1);
    tick(32'd100, 3'b111);
    tick(32'd101, 3'b111);
    poll(4);
    sample_irq(2'd0, 1'b0);
    sample_irq(2'd3, 1'b1);
    push_event(OpReserved, '1, '1, '1, 1'b1);
    tick(32'd202, 3'b101);
    poll(1);
    settle();

    // Zero interval with measuring channels; ticks wrap the millisecond counter.
    write_reg(REG_ACCEL_EN, 16'h0003);
    write_reg(REG_GYRO_EN, 16'h0004);
    write_reg(REG_INTERVAL, 16'h0000);
    settle();
    sample_irq(2'd0, 1'b0);
    sample_irq(2'd2, 1'b1);
    sample_irq(2'd1, 1'b0);
    sample_irq(2'd1, 1'b1);
    tick(32'd203, 3'b000);
    tick(32'd203, 3'b111);
    tick(32'hFFFF_FFFF, 3'b010);
    tick(32'd5, 3'b111);
    poll(4);
    settle();

    // Widest interval, all channels measuring, high register bits set.
    write_reg(REG_ACCEL_EN, 16'hFFFF);
    write_reg(REG_GYRO_EN, 16'hFFFF);
    write_reg(REG_INTERVAL, 16'hFFFF);
    write_reg(RegUnused, 16'hA5A5);
    settle();
    sample_irq(2'd2, 1'b1);
    tick(now_ms + 32'd65535, 3'b000);
    tick(now_ms + 32'd1, 3'b000);
    poll(2);
    settle();

    // Random phases, each under its own settings.
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      random_setup();
      if (phase == PressurePhase) begin
        // Receiver stalls for a long stretch while events keep coming.
        hold_asks = hold_asks + 1;
      end
      random_events(PhaseEvents);
      settle();
    end

    $display("Ran %0d events: %0d ticks (%0d checks), %0d data, %0d polls, %0d reserved.",
             n_ticks + n_data + n_polls + n_reserved, n_ticks, n_checks, n_data, n_polls,
             n_reserved);
    $display("Saw %0d links, %0d drops, %0d samples, %0d changes; %0d input stall cycles.",
             n_links, n_drops, n_samples, n_changes, input_stalls);
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("sensor_link_supervisor regression: pass");
    end else begin
      $display("sensor_link_supervisor regression: fail");
    end
    $finish;
  end

endmodule
